FILE: sv/macp_pkg.sv
// ----------------------------------------------------------------------------
// macp_pkg
// Shared constants and helpers for the MAC address text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package macp_pkg;

    // Character counter and field widths
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned ADDR_W  = 48;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned NIB_W   = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

    // String lengths of the two layouts
    localparam logic [CNT_W-1:0] SIX_LEN   = 5'd17;
    localparam logic [CNT_W-1:0] THREE_LEN = 5'd14;

    // Position of the final character of each layout (length - 1)
    localparam logic [CNT_W-1:0] SIX_LAST_POS   = SIX_LEN - 5'd1;
    localparam logic [CNT_W-1:0] THREE_LAST_POS = THREE_LEN - 5'd1;

    // Separator positions, one bit per character position.
    // Six groups: 2, 5, 8, 11, 14. Three groups: 4, 9.
    localparam logic [31:0] SIX_SEP_MASK   = 32'h0000_4924;
    localparam logic [31:0] THREE_SEP_MASK = 32'h0000_0210;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;

    // Layout codes
    typedef enum logic {
        LAYOUT_SIX   = 1'b0,
        LAYOUT_THREE = 1'b1
    } t_layout;

    // Decoded character: hex digit value plus a not-hex flag
    typedef struct packed {
        logic             not_hex;
        logic [NIB_W-1:0] value;
    } t_nibble;

    // Decode one character as a hex digit, either case
    function automatic t_nibble hex_nibble(input logic [CHAR_W-1:0] c);
        t_nibble      res;
        logic [CHAR_W-1:0] diff;
        res  = '{not_hex: 1'b1, value: '0};
        diff = '0;
        if (c >= CH_0 && c <= CH_9) begin
            diff = c - CH_0;
            res  = '{not_hex: 1'b0, value: diff[NIB_W-1:0]};
        end else if (c >= CH_UA && c <= CH_UF) begin
            diff = c - CH_UA + 8'd10;
            res  = '{not_hex: 1'b0, value: diff[NIB_W-1:0]};
        end else if (c >= CH_LA && c <= CH_LF) begin
            diff = c - CH_LA + 8'd10;
            res  = '{not_hex: 1'b0, value: diff[NIB_W-1:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: sv/mac_address_text_parser.sv
// ----------------------------------------------------------------------------
// mac_address_text_parser
// Checks and converts a MAC address string, one character per beat, into a
// 48-bit address. Six two-digit and three four-digit layouts are tracked
// side by side until the last character.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (low bit first)                    Beat
// s_axis    in   tdata: char_code[7:0]; tlast: is_last     one per character
// m_axis    out  tdata: address[47:0]; tuser: valid_res,   one per string,
//                layout                                    after last char
//
// One character per cycle, with no gap between strings, while no last character
// waits on a stalled result. The last character's beat passes through an input
// register, then the parse logic feeding the result register.
// Reset (i_rst_n low, synchronous) empties both registers and restores the
// parse state for a new string.
// A stalled result holds the pipe only when a last character waits behind
// it; ordinary characters keep flowing into the parse state.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_address_text_parser
    import macp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Character input
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [CHAR_W-1:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic               s_axis_tlast,   // is_last
    // Parse result
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [ADDR_W-1:0]       m_axis_tdata,   // [47:0] address
    output logic [1:0]              m_axis_tuser    // [0] valid_res, [1] layout
);

    // Input register
    logic               r_in_valid;
    logic [CHAR_W-1:0]  r_in_char;
    logic               r_in_last;

    // Parse state
    logic [CNT_W-1:0]   r_char_count, n_char_count;
    logic               r_six_ok,     n_six_ok;
    logic               r_three_ok,   n_three_ok;
    logic [ADDR_W-1:0]  r_six_val,    n_six_val;
    logic [ADDR_W-1:0]  r_three_val,  n_three_val;

    // Result register
    logic               r_out_valid;
    logic               r_out_ok;
    t_layout            r_out_layout;
    logic [ADDR_W-1:0]  r_out_addr;
    logic               n_out_ok;
    t_layout            n_out_layout;
    logic [ADDR_W-1:0]  n_out_addr;

    logic               w_out_free;
    logic               w_s1_go;
    t_nibble            w_nib;
    logic               w_is_colon;
    logic               w_is_dash;

    // Pipe control: a last character needs a free result register
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_s1_go       = r_in_valid && (w_out_free || !r_in_last);
    assign s_axis_tready = !r_in_valid || w_s1_go;

    // Capture the incoming character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Parse one character against both layouts
    always_comb begin
        w_nib       = hex_nibble(r_in_char);
        w_is_colon  = (r_in_char == CH_COLON);
        w_is_dash   = (r_in_char == CH_DASH);

        n_six_ok    = r_six_ok;
        n_six_val   = r_six_val;
        n_three_ok  = r_three_ok;
        n_three_val = r_three_val;

        // Six two-digit groups
        if (r_char_count < SIX_LEN) begin
            if (SIX_SEP_MASK[r_char_count]) begin
                if (!w_is_colon && !w_is_dash) begin
                    n_six_ok = 1'b0;
                end
            end else if (w_nib.not_hex) begin
                n_six_ok = 1'b0;
            end else begin
                n_six_val = {r_six_val[ADDR_W-NIB_W-1:0], w_nib.value};
            end
        end

        // Three four-digit groups
        if (r_char_count < THREE_LEN) begin
            if (THREE_SEP_MASK[r_char_count]) begin
                if (!w_is_dash) begin
                    n_three_ok = 1'b0;
                end
            end else if (w_nib.not_hex) begin
                n_three_ok = 1'b0;
            end else begin
                n_three_val = {r_three_val[ADDR_W-NIB_W-1:0], w_nib.value};
            end
        end

        // Saturate the character count
        n_char_count = (r_char_count != COUNT_MAX) ? r_char_count + 5'd1 : r_char_count;

        // Pick the result from the length and the layout flags
        n_out_ok     = 1'b0;
        n_out_layout = LAYOUT_SIX;
        n_out_addr   = '0;
        if (r_char_count == SIX_LAST_POS && n_six_ok) begin
            n_out_ok   = 1'b1;
            n_out_addr = n_six_val;
        end else if (r_char_count == THREE_LAST_POS && n_three_ok) begin
            n_out_ok     = 1'b1;
            n_out_layout = LAYOUT_THREE;
            n_out_addr   = n_three_val;
        end
    end

    // Advance the parse state; restart after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count <= '0;
            r_six_ok     <= 1'b1;
            r_three_ok   <= 1'b1;
            r_six_val    <= '0;
            r_three_val  <= '0;
        end else if (w_s1_go) begin
            if (r_in_last) begin
                r_char_count <= '0;
                r_six_ok     <= 1'b1;
                r_three_ok   <= 1'b1;
                r_six_val    <= '0;
                r_three_val  <= '0;
            end else begin
                r_char_count <= n_char_count;
                r_six_ok     <= n_six_ok;
                r_three_ok   <= n_three_ok;
                r_six_val    <= n_six_val;
                r_three_val  <= n_three_val;
            end
        end
    end

    // Load and drain the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_s1_go && r_in_last) begin
            r_out_ok     <= n_out_ok;
            r_out_layout <= n_out_layout;
            r_out_addr   <= n_out_addr;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_addr;
    assign m_axis_tuser  = {r_out_layout, r_out_ok};

    // Checks
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_go && r_in_last) |=> (r_char_count == '0 && r_six_ok && r_three_ok))
        else $error("parse state not restored after last character");

    a_zero_if_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_out_addr == '0 && r_out_layout == LAYOUT_SIX))
        else $error("invalid string gave nonzero address or layout");

    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_s1_go && r_in_last))
        else $error("result appeared without a last character");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !(w_s1_go && r_in_last))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: test/mac_address_text_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mac_address_text_parser_test
// Streams MAC address strings into the parser one character per beat and
// checks every result beat against a local model of the two-layout parse.
// Directed strings cover the layout extremes and the malformed cases. Random
// strings, mostly well formed, run under several source and sink stall mixes.
// ----------------------------------------------------------------------------

module mac_address_text_parser_test;
    import macp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef logic [CHAR_W-1:0] t_char_q [$];

    typedef struct {
        logic              valid;
        t_layout           layout;
        logic [ADDR_W-1:0] address;
    } t_parse_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [CHAR_W-1:0] s_axis_tdata;   // [7:0] char_code
    logic              s_axis_tlast;   // is_last
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [ADDR_W-1:0] m_axis_tdata;   // [47:0] address
    logic [1:0]        m_axis_tuser;   // [0] valid_res, [1] layout

    // Local copy of the parse state
    int                text_len = 0;
    logic              six_ok = 1'b1;
    logic              three_ok = 1'b1;
    logic [ADDR_W-1:0] six_acc = '0;
    logic [ADDR_W-1:0] three_acc = '0;

    t_parse_result     pending_results [$];
    int                error_count = 0;
    int                cycle_count = 0;
    int                chars_sent = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;

    mac_address_text_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("mac_address_text_parser_test failed");
            $finish;
        end
    end

    // Hex digit value, or -1 for anything else
    function automatic int digit_of(logic [CHAR_W-1:0] c);
        if (c >= CH_0 && c <= CH_9)
            return int'(c - CH_0);
        if (c >= CH_UA && c <= CH_UF)
            return int'(c - CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LF)
            return int'(c - CH_LA) + 10;
        return -1;
    endfunction

    // Advance the parse state by one accepted character; queue a result on last
    task automatic parse_char(logic [CHAR_W-1:0] c, logic last);
        int            pos;
        int            nib;
        t_parse_result res;
        pos = text_len;
        nib = digit_of(c);
        if (pos < SIX_LEN) begin
            if (pos % 3 == 2) begin
                if (c != CH_COLON && c != CH_DASH)
                    six_ok = 1'b0;
            end else if (nib < 0) begin
                six_ok = 1'b0;
            end else begin
                six_acc = {six_acc[ADDR_W-5:0], nib[3:0]};
            end
        end
        if (pos < THREE_LEN) begin
            if (pos % 5 == 4) begin
                if (c != CH_DASH)
                    three_ok = 1'b0;
            end else if (nib < 0) begin
                three_ok = 1'b0;
            end else begin
                three_acc = {three_acc[ADDR_W-5:0], nib[3:0]};
            end
        end
        if (text_len < COUNT_MAX)
            text_len++;
        if (last) begin
            res = '{valid: 1'b0, layout: LAYOUT_SIX, address: '0};
            if (pos + 1 == SIX_LEN && six_ok)
                res = '{valid: 1'b1, layout: LAYOUT_SIX, address: six_acc};
            else if (pos + 1 == THREE_LEN && three_ok)
                res = '{valid: 1'b1, layout: LAYOUT_THREE, address: three_acc};
            pending_results.push_back(res);
            text_len  = 0;
            six_ok    = 1'b1;
            three_ok  = 1'b1;
            six_acc   = '0;
            three_acc = '0;
        end
    endtask

    // Send one character beat, with random idle cycles ahead of it
    task automatic send_char(logic [CHAR_W-1:0] c, logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        parse_char(c, last);
        chars_sent++;
    endtask

    task automatic send_text(t_char_q txt);
        foreach (txt[i])
            send_char(txt[i], i == txt.size() - 1);
    endtask

    function automatic t_char_q text_of(string s);
        t_char_q txt;
        for (int i = 0; i < s.len(); i++)
            txt.push_back(s[i]);
        return txt;
    endfunction

    function automatic logic [CHAR_W-1:0] random_hex_char();
        int nib;
        nib = $urandom_range(0, 15);
        if (nib < 10)
            return CH_0 + nib[CHAR_W-1:0];
        return ($urandom_range(0, 1) ? CH_UA : CH_LA) + nib[CHAR_W-1:0] - 8'd10;
    endfunction

    // Well-formed string of either layout with random digits and separators
    function automatic t_char_q well_formed_text(t_layout lay);
        t_char_q txt;
        if (lay == LAYOUT_SIX) begin
            for (int pos = 0; pos < SIX_LEN; pos++)
                if (pos % 3 == 2)
                    txt.push_back($urandom_range(0, 1) ? CH_COLON : CH_DASH);
                else
                    txt.push_back(random_hex_char());
        end else begin
            for (int pos = 0; pos < THREE_LEN; pos++)
                txt.push_back(pos % 5 == 4 ? CH_DASH : random_hex_char());
        end
        return txt;
    endfunction

    // Mostly well-formed strings; the rest corrupted, cut, stretched or noise
    function automatic t_char_q random_text();
        t_char_q txt;
        t_layout lay;
        int      extra;
        int      noise;
        lay = $urandom_range(0, 1) ? LAYOUT_SIX : LAYOUT_THREE;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                txt = well_formed_text(LAYOUT_SIX);
            end
            4, 5, 6: begin
                txt = well_formed_text(LAYOUT_THREE);
            end
            7: begin
                txt = well_formed_text(lay);
                noise = $urandom_range(0, 255);
                txt[$urandom_range(0, txt.size() - 1)] = noise[CHAR_W-1:0];
            end
            8: begin
                extra = $urandom_range(1, 40);
                repeat (extra) begin
                    noise = $urandom_range(0, 255);
                    txt.push_back(noise[CHAR_W-1:0]);
                end
            end
            default: begin
                txt = well_formed_text(lay);
                if ($urandom_range(0, 1)) begin
                    void'(txt.pop_back());
                end else begin
                    extra = $urandom_range(1, 20);
                    repeat (extra) txt.push_back(random_hex_char());
                end
            end
        endcase
        return txt;
    endfunction

    // Hold the source until every queued result has been seen
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Check each result beat against the oldest prediction; drive the sink
    always @(posedge i_clk) begin
        t_parse_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: valid=%0b layout=%0b address=%h",
                         $time, m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser[0] !== want.valid) begin
                    $display("%0t: valid_res mismatch: expected %0b, got %0b",
                             $time, want.valid, m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tuser[1] !== want.layout) begin
                    $display("%0t: layout mismatch: expected %0b, got %0b",
                             $time, want.layout, m_axis_tuser[1]);
                    error_count++;
                end
                if (m_axis_tdata !== want.address) begin
                    $display("%0t: address mismatch: expected %h, got %h",
                             $time, want.address, m_axis_tdata);
                    error_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Valid strings at the digit extremes, both layouts, mixed separators
    task automatic test_reference_strings();
        send_text(text_of("ff:ff:ff:ff:ff:ff"));
        send_text(text_of("00-00:00-00:00-00"));
        send_text(text_of("FFFF-ffff-0000"));
        send_text(text_of("9aAf-0000-Fa09"));
    endtask

    // Wrong lengths, bad separators, NUL and high codes, a saturating length
    task automatic test_malformed_strings();
        t_char_q txt;
        send_text(text_of("0"));
        send_text(text_of("ab:cd:ef:01:23:4"));
        send_text(text_of("ab:cd:ef:01:23:456"));
        send_text(text_of("abcd:ef01:2345"));
        send_text(text_of("ab.cd:ef:01:23:45"));
        send_text(text_of("abcg-ef01-2345"));
        txt = text_of("ab:cd:ef:01:23:45");
        txt[4] = 8'h00;
        send_text(txt);
        txt = text_of("abcd-ef01-2345");
        txt[7] = 8'hff;
        send_text(txt);
        txt = text_of("ab:cd:ef:01:23:45");
        txt[16] = 8'h80;
        send_text(txt);
        txt = {};
        repeat (40) txt.push_back(CH_LA);
        send_text(txt);
    endtask

    // Random strings until the character budget for this phase is spent
    task automatic test_random_traffic(int char_budget);
        int stop_at;
        stop_at = chars_sent + char_budget;
        while (chars_sent < stop_at)
            send_text(random_text());
    endtask

    // Let the pipe run dry between strings, then resume
    task automatic test_drain_pause();
        send_text(random_text());
        wait_results_drained();
        send_text(random_text());
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reference_strings();
        test_malformed_strings();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(185);

        send_idle_pct  = 56;
        recv_stall_pct = 0;
        test_random_traffic(185);
        test_drain_pause();

        send_idle_pct  = 0;
        recv_stall_pct = 56;
        test_random_traffic(185);

        send_idle_pct  = 15;
        recv_stall_pct = 15;
        test_random_traffic(185);

        // Drain, then allow the pipe to settle
        wait_results_drained();
        repeat (6) @(posedge i_clk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("mac_address_text_parser_test passed");
        end else begin
            $display("mac_address_text_parser_test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/macp_pkg.sv
sv/mac_address_text_parser.sv
test/mac_address_text_parser_test.sv
